@@ hdl/amsc_pkg.sv @@
// ----------------------------------------------------------------------------
// amsc_pkg
// Types and constants shared by the auto mouse layer scroll controller.
// ----------------------------------------------------------------------------
package amsc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLICKABLE_MOVEMENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_V_REVERSE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_H_REVERSE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_V_STEP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_H_STEP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICKABLE_TIMEOUT  = 3'd5;

	// configuration reset values
	localparam logic [14:0] RST_CLICKABLE_MOVEMENT = 15'd50;
	localparam logic [7:0]  RST_SCROLL_STEP        = 8'd50;
	localparam logic [15:0] RST_CLICKABLE_TIMEOUT  = 16'd1000;

	// key kinds
	localparam logic [2:0] KIND_BUTTON_LAST = 3'd2;
	localparam logic [2:0] KIND_SCROLL      = 3'd3;
	localparam logic [2:0] KIND_MODIFIER    = 3'd4;
	localparam logic [2:0] KIND_OTHER       = 3'd5;

	localparam logic [4:0]  LOCK_COUNTS   = 5'd30;
	localparam logic [15:0] WAIT_LIMIT_MS = 16'd50;
	localparam logic [8:0]  STEP_MAX      = 9'd128;

	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_WAITING   = 3'd1,
		MODE_CLICKABLE = 3'd2,
		MODE_CLICKING  = 3'd3,
		MODE_SCROLLING = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_DIV  = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_status_t;

endpackage

@@ hdl/amsc_div.sv @@
// ----------------------------------------------------------------------------
// amsc_div
// Restoring divider, 9-bit dividend by 8-bit divisor, three quotient bits
// per cycle.
// ----------------------------------------------------------------------------
module amsc_div (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [8:0] dividend,
	input  logic [7:0] divisor,
	output logic [8:0] quot,
	output logic [7:0] rem,
	output logic       done
);

	localparam int BITS_PER_CYCLE = 3;

	logic [8:0] q_q;
	logic [7:0] r_q;
	logic [7:0] d_q;
	logic [1:0] cnt_q;
	logic       busy_q;
	logic       done_q;
	logic [8:0] q_nxt;
	logic [7:0] r_nxt;

	always_comb begin
		logic [8:0] t;
		logic [8:0] q;
		logic [7:0] r;
		q = q_q;
		r = r_q;
		for (int i = 0; i < BITS_PER_CYCLE; i++) begin
			t = {r, q[8]};
			if (t >= {1'b0, d_q}) begin
				t = t - {1'b0, d_q};
				q = {q[7:0], 1'b1};
			end else begin
				q = {q[7:0], 1'b0};
			end
			r = t[7:0];
		end
		q_nxt = q;
		r_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= 2'd2;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == 2'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= q_nxt;
			r_q <= r_nxt;
		end
	end

	assign quot = q_q;
	assign rem  = r_q;
	assign done = done_q;

endmodule

@@ hdl/amsc_dp.sv @@
// ----------------------------------------------------------------------------
// amsc_dp
// Datapath: configuration registers, item registers, mode state, scroll
// accumulators, wheel step divider and the result register.
// ----------------------------------------------------------------------------
module amsc_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  amsc_pkg::dp_cmd_t                    cmd,
	output amsc_pkg::dp_status_t                 status,
	input  logic                                 cfg_we,
	input  logic [amsc_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [amsc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 func,
	input  logic [15:0]                          now_ms,
	input  logic signed [7:0]                    dx,
	input  logic signed [7:0]                    dy,
	input  logic [2:0]                           key_kind,
	input  logic                                 pressed,
	output logic signed [7:0]                    out_x,
	output logic signed [7:0]                    out_y,
	output logic signed [8:0]                    out_h,
	output logic signed [8:0]                    out_v,
	output logic [2:0]                           buttons,
	output logic                                 click_layer_on,
	output logic                                 pass_key
);

	// configuration
	logic [14:0] clickable_movement_q;
	logic        scroll_v_reverse_q;
	logic        scroll_h_reverse_q;
	logic [7:0]  scroll_v_step_q;
	logic [7:0]  scroll_h_step_q;
	logic [15:0] clickable_timeout_q;

	// item
	logic        func_q;
	logic [15:0] now_q;
	logic [7:0]  dx_q;
	logic [7:0]  dy_q;
	logic [2:0]  kind_q;
	logic        pressed_q;

	// block state
	amsc_pkg::mode_t mode_q, mode_n;
	logic [15:0] mark_q, mark_n;
	logic [4:0]  lock_q, lock_n;
	logic [15:0] sum_q, sum_n;
	logic [8:0]  acc_v_q, acc_v_n;
	logic [8:0]  acc_h_q, acc_h_n;
	logic [2:0]  bits_q, bits_n;
	logic        layer_q, layer_n;

	// result
	logic [7:0] ox_n, oy_n, out_x_q, out_y_q;
	logic [8:0] oh_n, ov_n, out_h_q, out_v_q;
	logic       pass_n, pass_q;

	// scroll arithmetic
	logic [7:0] ax, ay;
	logic [8:0] mag;
	logic       vert;
	logic       moving;
	logic [9:0] sum_acc_v, sum_acc_h, acc_sel, acc_abs;
	logic       acc_neg, acc_zero;
	logic [7:0] div_divisor;
	logic [8:0] div_dividend;
	logic [8:0] div_quot;
	logic [7:0] div_rem;
	logic       div_done;
	logic [8:0] steps_sat;
	logic [8:0] steps_out;
	logic [8:0] new_acc;
	logic       step_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clickable_movement_q <= amsc_pkg::RST_CLICKABLE_MOVEMENT;
			scroll_v_reverse_q   <= 1'b0;
			scroll_h_reverse_q   <= 1'b0;
			scroll_v_step_q      <= amsc_pkg::RST_SCROLL_STEP;
			scroll_h_step_q      <= amsc_pkg::RST_SCROLL_STEP;
			clickable_timeout_q  <= amsc_pkg::RST_CLICKABLE_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				amsc_pkg::CFG_CLICKABLE_MOVEMENT: clickable_movement_q <= cfg_data[14:0];
				amsc_pkg::CFG_SCROLL_V_REVERSE:   scroll_v_reverse_q   <= cfg_data[0];
				amsc_pkg::CFG_SCROLL_H_REVERSE:   scroll_h_reverse_q   <= cfg_data[0];
				amsc_pkg::CFG_SCROLL_V_STEP:      scroll_v_step_q      <= cfg_data[7:0];
				amsc_pkg::CFG_SCROLL_H_STEP:      scroll_h_step_q      <= cfg_data[7:0];
				amsc_pkg::CFG_CLICKABLE_TIMEOUT:  clickable_timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= func;
			now_q     <= now_ms;
			dx_q      <= dx;
			dy_q      <= dy;
			kind_q    <= key_kind;
			pressed_q <= pressed;
		end
	end

	// motion magnitudes and axis choice
	assign ax     = dx_q[7] ? (~dx_q + 8'd1) : dx_q;
	assign ay     = dy_q[7] ? (~dy_q + 8'd1) : dy_q;
	assign mag    = {1'b0, ax} + {1'b0, ay};
	assign vert   = {ay, 1'b0} > {1'b0, ax};
	assign moving = (dx_q != 8'd0) || (dy_q != 8'd0);

	// accumulator plus this poll, magnitude less one feeds the divider
	assign sum_acc_v = {acc_v_q[8], acc_v_q} + {{2{dy_q[7]}}, dy_q};
	assign sum_acc_h = {acc_h_q[8], acc_h_q} + {{2{dx_q[7]}}, dx_q};
	assign acc_sel   = vert ? sum_acc_v : sum_acc_h;
	assign acc_neg   = acc_sel[9];
	assign acc_abs   = acc_neg ? (~acc_sel + 10'd1) : acc_sel;
	assign acc_zero  = (acc_sel == 10'd0);

	always_comb begin
		logic [7:0] s;
		s = vert ? scroll_v_step_q : scroll_h_step_q;
		div_divisor = (s == 8'd0) ? 8'd1 : s;
	end

	assign div_dividend = acc_zero ? 9'd0 : (acc_abs[8:0] - 9'd1);

	amsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quot     (div_quot),
		.rem      (div_rem),
		.done     (div_done)
	);

	// remainder plus one is what stays in the accumulator
	always_comb begin
		logic [8:0] keep;
		keep      = {1'b0, div_rem} + 9'd1;
		new_acc   = acc_zero ? 9'd0 : (acc_neg ? (~keep + 9'd1) : keep);
		steps_sat = acc_zero ? 9'd0 : ((div_quot > amsc_pkg::STEP_MAX) ?
			amsc_pkg::STEP_MAX : div_quot);
		// horizontal wheel runs opposite to the accumulator sign
		step_neg  = vert ? (acc_neg ^ scroll_v_reverse_q) : (~acc_neg ^ scroll_h_reverse_q);
		steps_out = step_neg ? (~steps_sat + 9'd1) : steps_sat;
	end

	always_comb begin
		logic [15:0] elapsed;
		logic [16:0] sum_wide;
		logic [15:0] sum_sat;
		logic [4:0]  lock_tmp;
		logic [2:0]  bmask;
		logic        to_clickable;
		logic        to_idle;

		mode_n  = mode_q;
		mark_n  = mark_q;
		lock_n  = lock_q;
		sum_n   = sum_q;
		acc_v_n = acc_v_q;
		acc_h_n = acc_h_q;
		bits_n  = bits_q;
		layer_n = layer_q;
		ox_n    = 8'd0;
		oy_n    = 8'd0;
		oh_n    = 9'd0;
		ov_n    = 9'd0;
		pass_n  = 1'b0;

		elapsed      = now_q - mark_q;
		sum_wide     = {1'b0, sum_q} + {8'd0, mag};
		sum_sat      = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
		lock_tmp     = ({4'd0, lock_q} > mag) ? (lock_q - mag[4:0]) : 5'd0;
		bmask        = 3'b001 << kind_q[1:0];
		to_clickable = 1'b0;
		to_idle      = 1'b0;

		if (func_q) begin
			if (kind_q <= amsc_pkg::KIND_BUTTON_LAST) begin
				to_clickable = 1'b1;
				if (pressed_q) begin
					bits_n = bits_q | bmask;
					lock_n = amsc_pkg::LOCK_COUNTS;
				end else begin
					bits_n = bits_q & ~bmask;
				end
			end else if (kind_q == amsc_pkg::KIND_SCROLL) begin
				if (pressed_q) begin
					mode_n = amsc_pkg::MODE_SCROLLING;
				end else begin
					to_clickable = 1'b1;
				end
			end else begin
				pass_n = 1'b1;
				if (pressed_q) begin
					if (mode_q == amsc_pkg::MODE_CLICKING ||
					    mode_q == amsc_pkg::MODE_SCROLLING) begin
						to_clickable = 1'b1;
						pass_n       = 1'b0;
					end else if (kind_q == amsc_pkg::KIND_MODIFIER) begin
						to_clickable = 1'b1;
					end else begin
						to_idle = 1'b1;
					end
				end
			end
		end else if (moving) begin
			ox_n = dx_q;
			oy_n = dy_q;
			case (mode_q)
				amsc_pkg::MODE_CLICKABLE: mark_n = now_q;
				amsc_pkg::MODE_CLICKING: begin
					lock_n = lock_tmp;
					if (lock_tmp != 5'd0) begin
						ox_n = 8'd0;
						oy_n = 8'd0;
					end
				end
				amsc_pkg::MODE_SCROLLING: begin
					ox_n = 8'd0;
					oy_n = 8'd0;
					if (vert) begin
						acc_v_n = new_acc;
						ov_n    = steps_out;
					end else begin
						acc_h_n = new_acc;
						oh_n    = steps_out;
					end
				end
				amsc_pkg::MODE_WAITING: begin
					if (sum_sat >= {1'b0, clickable_movement_q}) begin
						sum_n        = 16'd0;
						to_clickable = 1'b1;
					end else begin
						sum_n = sum_sat;
					end
				end
				default: begin
					mark_n = now_q;
					mode_n = amsc_pkg::MODE_WAITING;
					sum_n  = 16'd0;
				end
			endcase
		end else begin
			case (mode_q) inside
				amsc_pkg::MODE_CLICKING, amsc_pkg::MODE_SCROLLING: ;
				amsc_pkg::MODE_CLICKABLE: begin
					if (elapsed > clickable_timeout_q) to_idle = 1'b1;
				end
				amsc_pkg::MODE_WAITING: begin
					if (elapsed > amsc_pkg::WAIT_LIMIT_MS) begin
						sum_n  = 16'd0;
						mode_n = amsc_pkg::MODE_IDLE;
					end
				end
				default: begin
					sum_n  = 16'd0;
					mode_n = amsc_pkg::MODE_IDLE;
				end
			endcase
		end

		if (to_clickable) begin
			layer_n = 1'b1;
			mark_n  = now_q;
			mode_n  = amsc_pkg::MODE_CLICKABLE;
		end
		// a button press leaves the block in clicking
		if (func_q && kind_q <= amsc_pkg::KIND_BUTTON_LAST && pressed_q) begin
			mode_n = amsc_pkg::MODE_CLICKING;
		end
		if (to_idle) begin
			mode_n  = amsc_pkg::MODE_IDLE;
			layer_n = 1'b0;
			acc_v_n = 9'd0;
			acc_h_n = 9'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= amsc_pkg::MODE_IDLE;
			mark_q  <= '0;
			lock_q  <= '0;
			sum_q   <= '0;
			acc_v_q <= '0;
			acc_h_q <= '0;
			bits_q  <= '0;
			layer_q <= 1'b0;
		end else if (cmd.commit) begin
			mode_q  <= mode_n;
			mark_q  <= mark_n;
			lock_q  <= lock_n;
			sum_q   <= sum_n;
			acc_v_q <= acc_v_n;
			acc_h_q <= acc_h_n;
			bits_q  <= bits_n;
			layer_q <= layer_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_x_q <= ox_n;
			out_y_q <= oy_n;
			out_h_q <= oh_n;
			out_v_q <= ov_n;
			pass_q  <= pass_n;
		end
	end

	assign status.need_div = !func_q && moving && (mode_q == amsc_pkg::MODE_SCROLLING);
	assign status.div_done = div_done;

	assign out_x          = out_x_q;
	assign out_y          = out_y_q;
	assign out_h          = out_h_q;
	assign out_v          = out_v_q;
	assign buttons        = bits_q;
	assign click_layer_on = layer_q;
	assign pass_key       = pass_q;

endmodule

@@ hdl/amsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// amsc_ctrl
// Sequencer: takes an item, evaluates it, runs the wheel step divider when
// needed and commits the result into the output register.
// ----------------------------------------------------------------------------
module amsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output amsc_pkg::dp_cmd_t    cmd,
	input  amsc_pkg::dp_status_t status
);

	amsc_pkg::ctrl_state_t state_q, state_n;
	logic out_valid_q;
	logic out_free;

	// result register is free or is emptied in this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			amsc_pkg::ST_IDLE: begin
				if (in_valid) state_n = amsc_pkg::ST_EXEC;
			end
			amsc_pkg::ST_EXEC: begin
				if (status.need_div) state_n = amsc_pkg::ST_DIV;
				else if (out_free) state_n = amsc_pkg::ST_IDLE;
			end
			amsc_pkg::ST_DIV: begin
				if (status.div_done && out_free) state_n = amsc_pkg::ST_IDLE;
			end
			default: state_n = amsc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			amsc_pkg::ST_IDLE: cmd.load = in_valid;
			amsc_pkg::ST_EXEC: begin
				cmd.div_start = status.need_div;
				cmd.commit    = !status.need_div && out_free;
			end
			amsc_pkg::ST_DIV: cmd.commit = status.div_done && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= amsc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != amsc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("result committed over an untaken transaction");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == amsc_pkg::ST_EXEC))
		else $error("accepted transaction not evaluated");

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == amsc_pkg::ST_DIV && !status.div_done) |=> (state_q == amsc_pkg::ST_DIV))
		else $error("left divide state before quotient ready");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

endmodule

@@ hdl/auto_mouse_layer_scroll_controller.sv @@
// ----------------------------------------------------------------------------
// auto_mouse_layer_scroll_controller
// Trackball report filter with automatic click layer and scroll mode.
// ----------------------------------------------------------------------------
// One item in flight at a time. A key event or a motion poll outside scroll
// mode is accepted, then evaluated and committed; a motion poll in scroll
// mode also runs the wheel step divider between evaluation and commit, which
// resolves three quotient bits a cycle and then flags completion. The result
// sits in an output register, so the next item is accepted while the
// previous transaction waits to be taken; an item only holds in evaluation
// when the output register is still full at commit time.
module auto_mouse_layer_scroll_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [amsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [amsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [15:0]                     now_ms,
	input  logic signed [7:0]               dx,
	input  logic signed [7:0]               dy,
	input  logic [2:0]                      key_kind,
	input  logic                            pressed,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [7:0]               out_x,
	output logic signed [7:0]               out_y,
	output logic signed [8:0]               out_h,
	output logic signed [8:0]               out_v,
	output logic [2:0]                      buttons,
	output logic                            click_layer_on,
	output logic                            pass_key
);

	amsc_pkg::dp_cmd_t    cmd;
	amsc_pkg::dp_status_t status;

	amsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	amsc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.func           (func),
		.now_ms         (now_ms),
		.dx             (dx),
		.dy             (dy),
		.key_kind       (key_kind),
		.pressed        (pressed),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_h          (out_h),
		.out_v          (out_v),
		.buttons        (buttons),
		.click_layer_on (click_layer_on),
		.pass_key       (pass_key)
	);

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the auto mouse layer scroll controller against a behavioral
// predictor that runs alongside it. A directed run covers the field extremes
// and each mode transition. Random episodes of motion bursts, clicks and
// scrolls follow under several register settings, with both handshakes
// idling and stalling at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LIMIT_CYCLES = 600000;
	localparam int PHASE_REPORTS = 240;
	localparam int LONG_HOLD = 400;
	localparam int V_DOMINANCE = 2;

	typedef struct {
		logic              func;
		logic [15:0]       stamp_ms;
		logic signed [7:0] dx;
		logic signed [7:0] dy;
		logic [2:0]        kind;
		logic              pressed;
	} report_in_t;

	typedef struct {
		logic signed [7:0] x;
		logic signed [7:0] y;
		logic signed [8:0] h;
		logic signed [8:0] v;
		logic [2:0]        buttons;
		logic              layer;
		logic              pass;
	} report_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [amsc_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [amsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = 1'b0;
	logic [15:0] now_ms = '0;
	logic signed [7:0] dx = '0;
	logic signed [7:0] dy = '0;
	logic [2:0] key_kind = '0;
	logic pressed = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [7:0] out_x;
	logic signed [7:0] out_y;
	logic signed [8:0] out_h;
	logic signed [8:0] out_v;
	logic [2:0] buttons;
	logic click_layer_on;
	logic pass_key;

	auto_mouse_layer_scroll_controller dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .now_ms(now_ms), .dx(dx), .dy(dy),
		.key_kind(key_kind), .pressed(pressed),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_h(out_h), .out_v(out_v),
		.buttons(buttons), .click_layer_on(click_layer_on), .pass_key(pass_key)
	);

	always #10 clk = ~clk;

	report_in_t pending_reports[$];
	report_out_t expected_reports[$];
	int n_queued = 0;
	int n_accepted = 0;
	int n_errors = 0;
	int cycle_count = 0;
	logic [15:0] clock_ms = '0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;
	logic in_taken = 1'b0;

	// filter state and register copies
	amsc_pkg::mode_t mode = amsc_pkg::MODE_IDLE;
	logic [15:0] mark_ms = '0;
	int lock_left = 0;
	int move_total = 0;
	int acc_v = 0;
	int acc_h = 0;
	logic [2:0] btn_bits = '0;
	logic layer_en = 1'b0;
	logic [14:0] cfg_move = amsc_pkg::RST_CLICKABLE_MOVEMENT;
	logic rev_v = 1'b0;
	logic rev_h = 1'b0;
	logic [7:0] step_v = amsc_pkg::RST_SCROLL_STEP;
	logic [7:0] step_h = amsc_pkg::RST_SCROLL_STEP;
	logic [15:0] cfg_timeout = amsc_pkg::RST_CLICKABLE_TIMEOUT;

	function automatic void open_layer(input logic [15:0] stamp);
		layer_en = 1'b1;
		mark_ms = stamp;
		mode = amsc_pkg::MODE_CLICKABLE;
	endfunction

	function automatic void close_layer();
		mode = amsc_pkg::MODE_IDLE;
		layer_en = 1'b0;
		acc_v = 0;
		acc_h = 0;
	endfunction

	// whole wheel steps out of one accumulator, remainder stays behind
	function automatic int drain_steps(input logic vert);
		int s, a, n, acc;
		acc = vert ? acc_v : acc_h;
		s = vert ? int'(step_v) : int'(step_h);
		if (s == 0)
			s = 1;
		a = acc < 0 ? -acc : acc;
		if (a <= s)
			return 0;
		n = (a - 1) / s;
		a = a - n * s;
		acc = acc < 0 ? -a : a;
		if (vert)
			acc_v = acc;
		else
			acc_h = acc;
		if (n > int'(amsc_pkg::STEP_MAX))
			n = int'(amsc_pkg::STEP_MAX);
		return acc < 0 ? -n : n;
	endfunction

	function automatic report_out_t filter_report(input report_in_t r);
		report_out_t o;
		int x, y, h, v, ax, ay;
		logic [15:0] elapsed;
		x = 0;
		y = 0;
		h = 0;
		v = 0;
		o.pass = 1'b0;
		if (r.func) begin
			if (r.kind <= amsc_pkg::KIND_BUTTON_LAST) begin
				open_layer(r.stamp_ms);
				if (r.pressed) begin
					btn_bits = btn_bits | (3'b001 << r.kind);
					mode = amsc_pkg::MODE_CLICKING;
					lock_left = int'(amsc_pkg::LOCK_COUNTS);
				end else begin
					btn_bits = btn_bits & ~(3'b001 << r.kind);
				end
			end else if (r.kind == amsc_pkg::KIND_SCROLL) begin
				if (r.pressed)
					mode = amsc_pkg::MODE_SCROLLING;
				else
					open_layer(r.stamp_ms);
			end else begin
				o.pass = 1'b1;
				if (r.pressed) begin
					if (mode == amsc_pkg::MODE_CLICKING ||
							mode == amsc_pkg::MODE_SCROLLING) begin
						open_layer(r.stamp_ms);
						o.pass = 1'b0;
					end else if (r.kind == amsc_pkg::KIND_MODIFIER) begin
						open_layer(r.stamp_ms);
					end else begin
						close_layer();
					end
				end
			end
		end else begin
			x = r.dx;
			y = r.dy;
			ax = x < 0 ? -x : x;
			ay = y < 0 ? -y : y;
			elapsed = r.stamp_ms - mark_ms;
			if (x != 0 || y != 0) begin
				case (mode)
				amsc_pkg::MODE_CLICKABLE: mark_ms = r.stamp_ms;
				amsc_pkg::MODE_CLICKING: begin
					lock_left = (ax + ay >= lock_left) ? 0 : lock_left - (ax + ay);
					if (lock_left > 0) begin
						x = 0;
						y = 0;
					end
				end
				amsc_pkg::MODE_SCROLLING: begin
					if (ay * V_DOMINANCE > ax) begin
						acc_v += y;
						v = drain_steps(1'b1);
						if (rev_v)
							v = -v;
					end else begin
						acc_h += x;
						h = -drain_steps(1'b0);
						if (rev_h)
							h = -h;
					end
					x = 0;
					y = 0;
				end
				amsc_pkg::MODE_WAITING: begin
					move_total += ax + ay;
					if (move_total > 65535)
						move_total = 65535;
					if (move_total >= int'(cfg_move)) begin
						move_total = 0;
						open_layer(r.stamp_ms);
					end
				end
				default: begin
					mark_ms = r.stamp_ms;
					mode = amsc_pkg::MODE_WAITING;
					move_total = 0;
				end
				endcase
			end else begin
				case (mode)
				amsc_pkg::MODE_CLICKING, amsc_pkg::MODE_SCROLLING: ;
				amsc_pkg::MODE_CLICKABLE: begin
					if (elapsed > cfg_timeout)
						close_layer();
				end
				amsc_pkg::MODE_WAITING: begin
					if (elapsed > amsc_pkg::WAIT_LIMIT_MS) begin
						move_total = 0;
						mode = amsc_pkg::MODE_IDLE;
					end
				end
				default: begin
					move_total = 0;
					mode = amsc_pkg::MODE_IDLE;
				end
				endcase
			end
		end
		o.x = x[7:0];
		o.y = y[7:0];
		o.h = h[8:0];
		o.v = v[8:0];
		o.buttons = btn_bits;
		o.layer = layer_en;
		return o;
	endfunction

	function automatic void check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
			n_errors++;
		end
	endfunction

	// don't-care fields of each item carry random values
	task automatic push_report(input logic f, input int ddx, input int ddy,
			input logic [2:0] k, input logic p, input int dt);
		report_in_t r;
		clock_ms = clock_ms + dt[15:0];
		r.func = f;
		r.stamp_ms = clock_ms;
		r.dx = f ? 8'($urandom) : ddx[7:0];
		r.dy = f ? 8'($urandom) : ddy[7:0];
		r.kind = f ? k : 3'($urandom);
		r.pressed = f ? p : 1'($urandom);
		pending_reports.push_back(r);
		n_queued++;
	endtask

	function automatic int rand_motion(input int maxmag);
		if ($urandom_range(0, 4) == 0)
			return 0;
		return int'($urandom_range(0, 2 * maxmag)) - maxmag;
	endfunction

	function automatic int rand_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return $urandom_range(0, 20);
		if (sel < 92)
			return $urandom_range(0, 1500);
		return $urandom_range(0, 65535);
	endfunction

	task automatic random_episode();
		int sel, len, i, m;
		logic [2:0] k;
		sel = $urandom_range(0, 99);
		len = $urandom_range(1, 10);
		if (sel < 25) begin
			m = $urandom_range(0, 1) ? 127 : 15;
			for (i = 0; i < len; i++)
				push_report(1'b0, rand_motion(m), rand_motion(m), 3'd0, 1'b0,
					$urandom_range(0, 30));
		end else if (sel < 45) begin
			k = 3'($urandom_range(0, int'(amsc_pkg::KIND_BUTTON_LAST)));
			push_report(1'b1, 0, 0, k, 1'b1, rand_gap());
			for (i = 0; i < len; i++)
				push_report(1'b0, rand_motion(12), rand_motion(12), 3'd0, 1'b0,
					$urandom_range(0, 30));
			if ($urandom_range(0, 4) != 0)
				push_report(1'b1, 0, 0, k, 1'b0, $urandom_range(0, 30));
		end else if (sel < 65) begin
			push_report(1'b1, 0, 0, amsc_pkg::KIND_SCROLL, 1'b1, rand_gap());
			for (i = 0; i < len; i++)
				push_report(1'b0, rand_motion(127), rand_motion(127), 3'd0, 1'b0,
					$urandom_range(0, 30));
			if ($urandom_range(0, 4) != 0)
				push_report(1'b1, 0, 0, amsc_pkg::KIND_SCROLL, 1'b0,
					$urandom_range(0, 30));
		end else if (sel < 78) begin
			push_report(1'b0, 0, 0, 3'd0, 1'b0, rand_gap());
		end else if (sel < 90) begin
			push_report(1'b1, 0, 0,
				3'($urandom_range(int'(amsc_pkg::KIND_MODIFIER), 7)),
				1'($urandom), rand_gap());
		end else begin
			push_report(1'($urandom), rand_motion(127), rand_motion(127), 3'($urandom),
				1'($urandom), $urandom_range(0, 65535));
		end
	endtask

	task automatic write_reg(input logic [amsc_pkg::CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[15:0];
		case (idx)
		amsc_pkg::CFG_CLICKABLE_MOVEMENT: cfg_move = val[14:0];
		amsc_pkg::CFG_SCROLL_V_REVERSE: rev_v = val[0];
		amsc_pkg::CFG_SCROLL_H_REVERSE: rev_h = val[0];
		amsc_pkg::CFG_SCROLL_V_STEP: step_v = val[7:0];
		amsc_pkg::CFG_SCROLL_H_STEP: step_h = val[7:0];
		amsc_pkg::CFG_CLICKABLE_TIMEOUT: cfg_timeout = val[15:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drain();
		while (n_accepted != n_queued || expected_reports.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// sender
	always @(negedge clk) begin : drive_reports
		report_in_t r;
		if (!in_valid || in_taken) begin
			if (arst_n && pending_reports.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				r = pending_reports.pop_front();
				in_valid <= 1'b1;
				func <= r.func;
				now_ms <= r.stamp_ms;
				dx <= r.dx;
				dy <= r.dy;
				key_kind <= r.kind;
				pressed <= r.pressed;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= $urandom_range(0, 99) < stall_pct;
		end
	end

	always @(posedge clk) begin : watch_ports
		report_in_t r;
		report_out_t e;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			// results first, so a transaction taken this edge cannot match itself
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual x=%0d y=%0d h=%0d v=%0d",
						$time, out_x, out_y, out_h, out_v);
					n_errors++;
				end else begin
					e = expected_reports.pop_front();
					check_field("out_x", e.x, out_x);
					check_field("out_y", e.y, out_y);
					check_field("out_h", e.h, out_h);
					check_field("out_v", e.v, out_v);
					check_field("buttons", e.buttons, buttons);
					check_field("click_layer_on", e.layer, click_layer_on);
					check_field("pass_key", e.pass, pass_key);
				end
			end
			if (in_valid && !in_stall) begin
				r.func = func;
				r.stamp_ms = now_ms;
				r.dx = dx;
				r.dy = dy;
				r.kind = key_kind;
				r.pressed = pressed;
				expected_reports.push_back(filter_report(r));
				n_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : run_phases
		int ph, target, mv, to, sv, sh;
		logic rv, rh;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed walk through the modes at reset settings
		push_report(1'b0, 0, 0, 3'd0, 1'b0, 0);
		push_report(1'b1, 0, 0, amsc_pkg::KIND_OTHER, 1'b1, 3);
		push_report(1'b0, 127, -127, 3'd0, 1'b0, 5);
		push_report(1'b0, -127, 127, 3'd0, 1'b0, 5);
		push_report(1'b0, 0, 0, 3'd0, 1'b0, 1002);
		push_report(1'b1, 0, 0, amsc_pkg::KIND_SCROLL, 1'b1, 2);
		push_report(1'b0, 0, 127, 3'd0, 1'b0, 2);
		push_report(1'b0, -127, 0, 3'd0, 1'b0, 2);
		push_report(1'b0, 0, 0, 3'd0, 1'b0, 2);
		push_report(1'b1, 0, 0, amsc_pkg::KIND_OTHER, 1'b1, 2);
		push_report(1'b1, 0, 0, 3'd0, 1'b1, 2);
		push_report(1'b0, 10, 5, 3'd0, 1'b0, 2);
		push_report(1'b0, 20, 0, 3'd0, 1'b0, 2);
		push_report(1'b1, 0, 0, 3'd0, 1'b0, 2);
		push_report(1'b1, 0, 0, 3'd1, 1'b1, 2);
		push_report(1'b1, 0, 0, 3'd2, 1'b1, 2);
		push_report(1'b1, 0, 0, 3'd1, 1'b0, 2);
		push_report(1'b1, 0, 0, amsc_pkg::KIND_MODIFIER, 1'b1, 2);
		push_report(1'b1, 0, 0, 3'd6, 1'b1, 2);
		push_report(1'b1, 0, 0, 3'd7, 1'b0, 2);
		push_report(1'b1, 0, 0, amsc_pkg::KIND_SCROLL, 1'b0, 2);
		push_report(1'b1, 0, 0, amsc_pkg::KIND_OTHER, 1'b1, 2);
		push_report(1'b0, 1, 0, 3'd0, 1'b0, 2);
		push_report(1'b0, 0, 0, 3'd0, 1'b0, 51);
		push_report(1'b0, 0, 0, 3'd0, 1'b0, 65000);
		wait_drain();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
			0: begin mv = 50; rv = 1'b0; rh = 1'b0; sv = 50; sh = 50; to = 1000; end
			1: begin mv = 5; rv = 1'b1; rh = 1'b0; sv = 1; sh = 255; to = 0; end
			2: begin mv = 32767; rv = 1'b0; rh = 1'b1; sv = 255; sh = 1; to = 65535; end
			// zero step behaves as a step of one
			3: begin mv = 20; rv = 1'b1; rh = 1'b1; sv = 0; sh = 0; to = 300; end
			default: begin
				mv = $urandom_range(5, 150);
				rv = 1'($urandom);
				rh = 1'($urandom);
				sv = $urandom_range(1, 255);
				sh = $urandom_range(1, 255);
				to = $urandom_range(0, 2000);
			end
			endcase
			write_reg(amsc_pkg::CFG_CLICKABLE_MOVEMENT, mv);
			write_reg(amsc_pkg::CFG_SCROLL_V_REVERSE, int'(rv));
			write_reg(amsc_pkg::CFG_SCROLL_H_REVERSE, int'(rh));
			write_reg(amsc_pkg::CFG_SCROLL_V_STEP, sv);
			write_reg(amsc_pkg::CFG_SCROLL_H_STEP, sh);
			write_reg(amsc_pkg::CFG_CLICKABLE_TIMEOUT, to);
			case (ph % 4)
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 56; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 56; end
			default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			// sender keeps offering while the receiver holds off
			if (ph == 4)
				hold_requests++;
			target = n_queued + PHASE_REPORTS;
			while (n_queued < target)
				random_episode();
			wait_drain();
		end

		repeat (20) @(posedge clk);
		if (n_errors == 0 && expected_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ files.f @@
hdl/amsc_pkg.sv
hdl/amsc_div.sv
hdl/amsc_dp.sv
hdl/amsc_ctrl.sv
hdl/auto_mouse_layer_scroll_controller.sv
tb/testbench.sv
